// File: rtl/core/iss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_pkg
// Shared constants, codes and controller/datapath types for the range table.
// ----------------------------------------------------------------------------
package iss_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int FIELD_BITS = 32;
    localparam int COUNT_BITS = 7;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_ERASE  = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture request
        logic rd;      // read entry at scan index
        logic eval;    // classify entry, write first piece
        logic eval2;   // write held second piece
        logic fin;     // place merged range if not yet placed
        logic commit;  // switch banks, load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic more;      // scan index below range count
        logic skip;      // empty range, no scan needed
        logic need2;     // current entry produces two writes
        logic out_free;  // result register can take a new result
    } t_stat;

endpackage

// File: rtl/core/iss_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_req_if / iss_rsp_if
// Valid/ready channels for requests and results of the range table.
// ----------------------------------------------------------------------------
interface iss_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] lo;
    logic [31:0] hi;

    modport source (output valid, action, lo, hi, input ready);
    modport sink   (input valid, action, lo, hi, output ready);
endinterface

interface iss_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] range_lo;
    logic [31:0] range_hi;
    logic [6:0]  range_count;
    logic [1:0]  status;

    modport source (output valid, found, range_lo, range_hi, range_count, status,
                    input ready);
    modport sink   (input valid, found, range_lo, range_hi, range_count, status,
                    output ready);
endinterface

// File: rtl/core/iss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_ctrl
// Sequencer: captures a request, walks the table entry by entry (read, then
// classify), then commits and hands the result to the output register.
// ----------------------------------------------------------------------------
module iss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  iss_pkg::t_stat i_stat,
    output logic           o_idle,
    output iss_pkg::t_cmd  o_cmd
);
    import iss_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_EVAL2 = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_idle = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                if (i_stat.skip || !i_stat.more) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.need2 ? S_EVAL2 : S_READ;
            end
            S_EVAL2: begin
                o_cmd.eval2 = 1'b1;
                n_state     = S_READ;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/core/iss_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_dp
// Datapath: two banks of range storage, scan/merge logic and result register.
// ----------------------------------------------------------------------------
module iss_dp #(
    parameter int CAPACITY   = iss_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = iss_pkg::VALUE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  iss_pkg::t_cmd  i_cmd,
    output iss_pkg::t_stat o_stat,
    input  logic [1:0]     i_action,
    input  logic [31:0]    i_lo,
    input  logic [31:0]    i_hi,
    iss_rsp_if.source      o_rsp
);
    import iss_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NW = $clog2(CAPACITY + 2);
    localparam int VB = VALUE_BITS;
    localparam int MD = 2 ** (IW + 1);

    // bank r_bank holds the live table; the scan rebuilds it in the other bank
    logic [VB-1:0] mem_s [MD];
    logic [VB-1:0] mem_e [MD];

    logic          r_bank;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_i;
    logic [NW-1:0] r_n;
    logic [1:0]    r_act;
    logic [VB-1:0] r_lo, r_hi, r_nlo, r_nhi, r_s, r_e, r_ps, r_pe;
    logic          r_placed, r_hits, r_split;
    logic          r_found;
    logic [VB-1:0] r_flo, r_fhi;

    logic          r_ovalid;
    logic          r_ofound;
    logic [31:0]   r_olo, r_ohi;
    logic [6:0]    r_ocnt;
    logic [1:0]    r_ostat;

    logic [63:0]   lo64, hi64, flo64, fhi64, cnt64;
    logic [VB-1:0] in_lo, in_hi;
    logic          is_ins, is_ers, empty;

    logic          w_en;
    logic [VB-1:0] w_s, w_e;
    logic          need2;
    logic [VB-1:0] p_s, p_e;
    logic          hit_m, split_m, found_m;
    logic          reject;
    logic [CW-1:0] n_count;
    logic [1:0]    stat_c;

    assign lo64  = {32'd0, i_lo};
    assign hi64  = {32'd0, i_hi};
    assign in_lo = lo64[VB-1:0];
    assign in_hi = hi64[VB-1:0];

    assign is_ins = (r_act == ACT_INSERT);
    assign is_ers = (r_act == ACT_ERASE);
    assign empty  = (is_ins || is_ers) && (r_hi <= r_lo);

    // classify the entry just read
    always_comb begin
        w_en    = 1'b0;
        w_s     = r_s;
        w_e     = r_e;
        need2   = 1'b0;
        p_s     = r_s;
        p_e     = r_e;
        hit_m   = 1'b0;
        split_m = 1'b0;
        found_m = 1'b0;
        if (is_ins) begin
            if (r_e < r_lo) begin
                w_en = 1'b1;
            end else if (r_s > r_hi) begin
                w_en = 1'b1;
                if (!r_placed) begin
                    w_s   = r_nlo;
                    w_e   = r_nhi;
                    need2 = 1'b1;
                end
            end else begin
                hit_m = 1'b1;
            end
        end else if (is_ers) begin
            if (r_e <= r_lo || r_s >= r_hi) begin
                w_en = 1'b1;
            end else if (r_s < r_lo && r_e > r_hi) begin
                w_en    = 1'b1;
                w_e     = r_lo;
                need2   = 1'b1;
                p_s     = r_hi;
                split_m = 1'b1;
            end else if (r_s < r_lo) begin
                w_en = 1'b1;
                w_e  = r_lo;
            end else if (r_e > r_hi) begin
                w_en = 1'b1;
                w_s  = r_hi;
            end
        end else begin
            found_m = (r_act == ACT_QUERY) && (r_s <= r_lo) && (r_lo < r_e);
        end
        if (!i_cmd.eval) begin
            w_en = 1'b0;
        end
        // held second piece, or the merged range at the end of an insert
        if (i_cmd.eval2) begin
            w_en = 1'b1;
            w_s  = r_ps;
            w_e  = r_pe;
        end else if (i_cmd.fin) begin
            w_en = is_ins && !empty && !r_placed;
            w_s  = r_nlo;
            w_e  = r_nhi;
        end
    end

    assign reject = (CW'(CAPACITY) <= r_count) &&
                    ((is_ins && !r_hits) || (is_ers && r_split));

    always_comb begin
        n_count = r_count;
        stat_c  = STAT_OK;
        if (empty) begin
            stat_c = STAT_EMPTY;
        end else if (reject) begin
            stat_c = STAT_FULL;
        end else if (is_ins || is_ers) begin
            n_count = (r_n > NW'(CAPACITY)) ? CW'(CAPACITY) : r_n[CW-1:0];
        end
    end

    assign o_stat.more     = (r_i < r_count);
    assign o_stat.skip     = empty;
    assign o_stat.need2    = need2;
    assign o_stat.out_free = !r_ovalid || o_rsp.ready;

    // storage: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_en && (r_n < NW'(CAPACITY))) begin
            mem_s[{~r_bank, r_n[IW-1:0]}] <= w_s;
            mem_e[{~r_bank, r_n[IW-1:0]}] <= w_e;
        end
        if (i_cmd.rd) begin
            r_s <= mem_s[{r_bank, r_i[IW-1:0]}];
            r_e <= mem_e[{r_bank, r_i[IW-1:0]}];
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act    <= i_action;
            r_lo     <= in_lo;
            r_hi     <= in_hi;
            r_nlo    <= in_lo;
            r_nhi    <= in_hi;
            r_i      <= '0;
            r_n      <= '0;
            r_placed <= 1'b0;
            r_hits   <= 1'b0;
            r_split  <= 1'b0;
            r_found  <= 1'b0;
            r_flo    <= in_lo;
            r_fhi    <= in_lo;
        end else begin
            if (w_en) begin
                r_n <= r_n + NW'(1);
            end
            if (i_cmd.rd) begin
                r_i <= r_i + CW'(1);
            end
            if (i_cmd.eval) begin
                if (need2) begin
                    r_ps <= p_s;
                    r_pe <= p_e;
                end
                if (need2 && is_ins) begin
                    r_placed <= 1'b1;
                end
                if (split_m) begin
                    r_split <= 1'b1;
                end
                if (hit_m) begin
                    r_hits <= 1'b1;
                    if (r_s < r_nlo) begin
                        r_nlo <= r_s;
                    end
                    if (r_e > r_nhi) begin
                        r_nhi <= r_e;
                    end
                end
                if (found_m && !r_found) begin
                    r_found <= 1'b1;
                    r_flo   <= r_s;
                    r_fhi   <= r_e;
                end
            end
        end
    end

    assign flo64 = 64'(r_flo);
    assign fhi64 = 64'(r_fhi);
    assign cnt64 = 64'(n_count);

    // table bookkeeping and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank   <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_ovalid <= 1'b1;
                r_count  <= n_count;
                if ((is_ins || is_ers) && !empty && !reject) begin
                    r_bank <= ~r_bank;
                end
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ostat <= stat_c;
            r_ocnt  <= cnt64[6:0];
            if (is_ins || is_ers) begin
                r_ofound <= 1'b0;
                r_olo    <= '0;
                r_ohi    <= '0;
            end else begin
                r_ofound <= r_found;
                r_olo    <= flo64[31:0];
                r_ohi    <= fhi64[31:0];
            end
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.found       = r_ofound;
    assign o_rsp.range_lo    = r_olo;
    assign o_rsp.range_hi    = r_ohi;
    assign o_rsp.range_count = r_ocnt;
    assign o_rsp.status      = r_ostat;

endmodule

// File: rtl/core/interval_set_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_set_table
// Sorted table of disjoint half-open ranges with insert, erase and query.
// ----------------------------------------------------------------------------
// Each request (insert, erase or point query) walks the whole stored table
// once: each stored range is read, then classified, and for an insert or
// erase the rebuilt entry is written into the spare bank, with one more
// write for the entry that splits or receives the new range; finish and
// commit steps follow. An empty or inverted range skips the walk. A result
// still held in the output register stalls the commit until it is taken.
// Insert merges with every overlapping or touching range; erase trims or
// splits. An empty or inverted range returns status 2 and leaves the table
// alone; an insert that needs a new slot, or an erase that splits, while the
// table is full returns status 1. A request is taken only while the block is
// idle; the finished result waits in an output register, so the next request
// is taken while the previous result is still held.
module interval_set_table #(
    parameter int CAPACITY   = iss_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = iss_pkg::VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iss_req_if.sink   i_req,
    iss_rsp_if.source o_rsp
);
    import iss_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  idle;

    // accept a request only when the sequencer is parked
    assign i_req.ready = idle;

    iss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_stat      (stat),
        .o_idle      (idle),
        .o_cmd       (cmd)
    );

    iss_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_action (i_req.action),
        .i_lo     (i_req.lo),
        .i_hi     (i_req.hi),
        .o_rsp    (o_rsp)
    );

endmodule

// File: sim/interval_set_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_set_table_tb
// Checks the range table against a predictor of its sorted range list over
// directed cases, dense random traffic with idles, and a long output stall.
// ----------------------------------------------------------------------------
module interval_set_table_tb;
    import iss_pkg::*;

    localparam int CAP       = CAPACITY_DEF;
    localparam int MAX_CYCLE = 2000000;

    typedef struct packed {
        logic        found;
        logic [31:0] range_lo;
        logic [31:0] range_hi;
        logic [6:0]  range_count;
        logic [1:0]  status;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    iss_req_if req_ch ();
    iss_rsp_if rsp_ch ();

    interval_set_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // model copy of the range list
    logic [31:0] mdl_lo [CAP];
    logic [31:0] mdl_hi [CAP];
    int          mdl_count;

    t_answer answer_q [$];
    int      errors;
    int      answers_seen;
    int      cycle;
    bit      hold_rsp;   // long stall of the result side
    int      idle_max;   // 0 turns off sender and receiver gaps
    int      rsp_gap;    // cycles left in the current receiver gap

    // requests mostly pick values from this window so ranges collide
    logic [31:0] span_base;
    int unsigned span_width;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int pick_gap();
        if (idle_max == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, idle_max);
    endfunction

    // Predict one answer and advance the model.
    function automatic t_answer predict_range_op(logic [1:0] act, logic [31:0] lo,
                                                 logic [31:0] hi);
        t_answer a;
        logic [31:0] ws [CAP+1];
        logic [31:0] we [CAP+1];
        logic [31:0] nlo, nhi;
        int n, hits;
        bit placed, blocked;
        a = '0;
        n = 0;
        hits = 0;
        placed = 0;
        blocked = 0;
        nlo = lo;
        nhi = hi;
        if (act == ACT_INSERT || act == ACT_ERASE) begin
            if (hi <= lo) begin
                a.status = STAT_EMPTY;
            end else if (act == ACT_INSERT) begin
                for (int i = 0; i < mdl_count; i++)
                    if (!(mdl_hi[i] < lo) && !(mdl_lo[i] > hi)) hits++;
                if (hits == 0 && mdl_count >= CAP) begin
                    a.status = STAT_FULL;
                end else begin
                    for (int i = 0; i < mdl_count; i++) begin
                        if (mdl_hi[i] < lo) begin
                            ws[n] = mdl_lo[i]; we[n] = mdl_hi[i]; n++;
                        end else if (mdl_lo[i] > hi) begin
                            if (!placed) begin
                                ws[n] = nlo; we[n] = nhi; n++; placed = 1;
                            end
                            ws[n] = mdl_lo[i]; we[n] = mdl_hi[i]; n++;
                        end else begin
                            if (mdl_lo[i] < nlo) nlo = mdl_lo[i];
                            if (mdl_hi[i] > nhi) nhi = mdl_hi[i];
                        end
                    end
                    if (!placed) begin
                        ws[n] = nlo; we[n] = nhi; n++;
                    end
                    for (int i = 0; i < n && i < CAP; i++) begin
                        mdl_lo[i] = ws[i]; mdl_hi[i] = we[i];
                    end
                    mdl_count = (n > CAP) ? CAP : n;
                end
            end else begin
                for (int i = 0; i < mdl_count; i++)
                    if (mdl_lo[i] < lo && mdl_hi[i] > hi && mdl_count >= CAP) blocked = 1;
                if (blocked) begin
                    a.status = STAT_FULL;
                end else begin
                    for (int i = 0; i < mdl_count; i++) begin
                        if (mdl_hi[i] <= lo || mdl_lo[i] >= hi) begin
                            ws[n] = mdl_lo[i]; we[n] = mdl_hi[i]; n++;
                        end else begin
                            if (mdl_lo[i] < lo) begin
                                ws[n] = mdl_lo[i]; we[n] = lo; n++;
                            end
                            if (mdl_hi[i] > hi) begin
                                ws[n] = hi; we[n] = mdl_hi[i]; n++;
                            end
                        end
                    end
                    for (int i = 0; i < n && i < CAP; i++) begin
                        mdl_lo[i] = ws[i]; mdl_hi[i] = we[i];
                    end
                    mdl_count = (n > CAP) ? CAP : n;
                end
            end
        end else begin
            // query, and the unused code answers as a miss
            a.range_lo = lo;
            a.range_hi = lo;
            if (act == ACT_QUERY) begin
                for (int i = 0; i < mdl_count; i++) begin
                    if (mdl_lo[i] <= lo && lo < mdl_hi[i] && !a.found) begin
                        a.found = 1'b1;
                        a.range_lo = mdl_lo[i];
                        a.range_hi = mdl_hi[i];
                    end
                end
            end
        end
        a.range_count = 7'(mdl_count);
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch at answer %0d: %s got %0h want %0h", answers_seen, what,
                 got, want);
    endtask

    // Send one request and queue its prediction on acceptance; valid stays
    // high after acceptance only when the next request follows at once.
    task automatic send_request(logic [1:0] act, logic [31:0] lo, logic [31:0] hi);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.lo     <= lo;
        req_ch.hi     <= hi;
        do @(posedge i_clk); while (!req_ch.ready);
        answer_q.push_back(predict_range_op(act, lo, hi));
    endtask

    // Receiver: mostly ready, with gaps of random length, unless held off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_gap      <= 0;
        end else if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_gap > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_gap      <= rsp_gap - 1;
        end else if (idle_max != 0 && rsp_ch.ready && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_gap      <= pick_gap();
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Check every accepted answer against the oldest prediction.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            answers_seen++;
            if (answer_q.size() == 0) begin
                report_mismatch("unexpected answer", 32'd0, 32'd0);
            end else begin
                want = answer_q.pop_front();
                if (rsp_ch.found != want.found)
                    report_mismatch("found", 32'(rsp_ch.found), 32'(want.found));
                if (rsp_ch.range_lo != want.range_lo)
                    report_mismatch("range_lo", rsp_ch.range_lo, want.range_lo);
                if (rsp_ch.range_hi != want.range_hi)
                    report_mismatch("range_hi", rsp_ch.range_hi, want.range_hi);
                if (rsp_ch.range_count != want.range_count)
                    report_mismatch("range_count", 32'(rsp_ch.range_count),
                                    32'(want.range_count));
                if (rsp_ch.status != want.status)
                    report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
            end
        end
    end

    function automatic logic [31:0] pick_point();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 3);
            default: return span_base + $urandom_range(0, span_width);
        endcase
    endfunction

    task automatic test_directed();
        send_request(ACT_QUERY, 32'd5, 32'd0);               // empty table
        send_request(ACT_INSERT, 32'd10, 32'd20);
        send_request(ACT_INSERT, 32'd20, 32'd30);            // touching merges
        send_request(ACT_INSERT, 32'd12, 32'd15);            // fully inside
        send_request(ACT_INSERT, 32'd40, 32'd40);            // empty
        send_request(ACT_ERASE, 32'd50, 32'd45);             // inverted
        send_request(ACT_QUERY, 32'd29, 32'd0);
        send_request(ACT_QUERY, 32'd30, 32'd0);
        send_request(ACT_ERASE, 32'd14, 32'd16);             // split
        send_request(ACT_QUERY, 32'd15, 32'hFFFF_FFFF);
        send_request(2'd3, 32'd12, 32'd0);                   // unused code
        send_request(ACT_INSERT, 32'd0, 32'hFFFF_FFFF);      // full width
        send_request(ACT_QUERY, 32'hFFFF_FFFE, 32'd0);
        send_request(ACT_ERASE, 32'd1, 32'hFFFF_FFFE);
        send_request(ACT_QUERY, 32'hFFFF_FFFF, 32'd0);
        send_request(ACT_ERASE, 32'd0, 32'hFFFF_FFFF);
        send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Fill to capacity with isolated ranges, then hit both full rejections.
    task automatic test_full_table();
        for (int i = 0; i < CAP; i++)
            send_request(ACT_INSERT, 32'(1000 + 4 * i), 32'(1003 + 4 * i));
        send_request(ACT_INSERT, 32'd5000, 32'd5001);        // needs a slot
        send_request(ACT_ERASE, 32'd1001, 32'd1002);         // split when full
        send_request(ACT_INSERT, 32'd1003, 32'd1004);        // merges, frees one
        send_request(ACT_ERASE, 32'd1008, 32'd1009);         // trim only
        send_request(ACT_ERASE, 32'd0, 32'hFFFF_FFFF);
    endtask

    // Hold the receiver while the sender keeps pushing.
    task automatic test_output_stall();
        fork
            begin
                hold_rsp = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_rsp = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                send_request(2'($urandom_range(0, 2)), pick_point(), pick_point());
        join
    endtask

    task automatic test_random(int count);
        logic [31:0] lo;
        logic [1:0]  act;
        for (int i = 0; i < count; i++) begin
            if (i % 200 == 0) begin
                span_base  = $urandom();
                span_width = (i % 400 == 0) ? 500 : 20000;
            end
            lo = pick_point();
            case ($urandom_range(0, 9))
                0, 1, 2, 3: act = ACT_INSERT;
                4, 5: act = ACT_ERASE;
                9: act = 2'($urandom_range(0, 3));
                default: act = ACT_QUERY;
            endcase
            if ($urandom_range(0, 15) == 0)
                send_request(act, lo, $urandom());
            else
                send_request(act, lo, lo + $urandom_range(1, span_width / 8));
        end
    endtask

    initial begin
        i_clk        = 1'b0;
        errors       = 0;
        answers_seen = 0;
        cycle        = 0;
        hold_rsp     = 1'b0;
        idle_max     = 3;
        span_base    = 32'd0;
        span_width   = 500;
        mdl_count    = 0;
        i_rst_n      = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.action = ACT_INSERT;
        req_ch.lo     = '0;
        req_ch.hi     = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_table();
        test_output_stall();
        idle_max = 0;
        test_random(300);
        idle_max = 3;
        test_random(1250);
        req_ch.valid <= 1'b0;

        wait (answer_q.size() == 0);
        repeat (2 * CAP + 20) @(posedge i_clk);
        $display("covered %0d answers: inserts, erases, queries, full table, stall",
                 answers_seen);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("errors %0d, left over %0d", errors, answer_q.size());
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/iss_pkg.sv
rtl/core/iss_if.sv
rtl/core/iss_ctrl.sv
rtl/core/iss_dp.sv
rtl/core/interval_set_table.sv
sim/interval_set_table_tb.sv
